// File: rtl/fisr_pkg.sv
`default_nettype none
package fisr_pkg;

    localparam logic [31:0] MAGIC_BITS = 32'h5f3759df;
    localparam logic [31:0] CANON_NAN  = 32'h7FC00000;
    localparam logic [31:0] ONE_HALF   = 32'h3F000000;
    localparam logic [31:0] THREE_HALF = 32'h3FC00000;

    // Unpacked single: class flags, sign, biased exponent, significand with hidden bit.
    typedef struct packed {
        logic        is_nan;
        logic        is_inf;
        logic        is_zero;
        logic        sign;
        logic [7:0]  expo;
        logic [23:0] sig;
    } fp_unp_t;

    // Flush a subnormal pattern to a zero of the same sign.
    function automatic logic [31:0] flush_sub(input logic [31:0] b);
        logic [31:0] r;
        r = b;
        if (b[30:23] == 8'd0 && b[22:0] != 23'd0)
        begin
            r = {b[31], 31'd0};
        end
        return r;
    endfunction

    function automatic fp_unp_t unpack(input logic [31:0] b);
        fp_unp_t u;
        u.sign    = b[31];
        u.expo    = b[30:23];
        u.is_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        u.is_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
        u.is_zero = (b[30:23] == 8'd0);
        u.sig     = {1'b1, b[22:0]};
        return u;
    endfunction

    // Round a normalised significand product and pack with flush to zero.
    // p is the 48-bit product, e the sum of biased exponents minus bias (signed).
    function automatic logic [31:0] mul_round(input logic s, input logic [47:0] p,
                                              input logic signed [10:0] e_in);
        logic [23:0]        m;
        logic               g;
        logic               st;
        logic [24:0]        mr;
        logic signed [10:0] e;
        logic signed [10:0] e_norm;
        logic [31:0]        r;
        e = e_in;
        if (p[47])
        begin
            m  = p[47:24];
            g  = p[23];
            st = |p[22:0];
            e  = e + 11'sd1;
        end
        else
        begin
            m  = p[46:23];
            g  = p[22];
            st = |p[21:0];
        end
        e_norm = e;
        mr = {1'b0, m} + {24'd0, g & (st | m[0])};
        if (mr[24])
        begin
            e  = e + 11'sd1;
            mr = {1'b0, mr[24:1]};
        end
        if (e >= 11'sd255)
        begin
            r = {s, 8'hFF, 23'd0};
        end
        else if (e <= 11'sd0)
        begin
            // Just below the smallest normal, the subnormal grid rounds up onto it.
            r = (e_norm == 11'sd0 && (&m)) ? {s, 8'd1, 23'd0} : {s, 31'd0};
        end
        else
        begin
            r = {s, e[7:0], mr[22:0]};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// File: rtl/fisr_fmul.sv
`default_nettype none
// Two-stage single-precision multiplier, round to nearest even, flush to zero.
module fisr_fmul (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        en,
    input  wire logic        in_valid,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    input  wire logic [31:0] side_in,
    output logic             out_valid,
    output logic [31:0]      prod,
    output logic [31:0]      side_out
);

    fisr_pkg::fp_unp_t ua;
    fisr_pkg::fp_unp_t ub;
    logic              sp_nan;
    logic              sp_inf;
    logic              sp_zero;

    logic                v1_reg;
    logic [47:0]         p_reg;
    logic signed [10:0]  e_reg;
    logic                s_reg;
    logic [1:0]          cls_reg;
    logic [31:0]         side1_reg;

    localparam logic [1:0] CLS_NUM  = 2'd0;
    localparam logic [1:0] CLS_NAN  = 2'd1;
    localparam logic [1:0] CLS_INF  = 2'd2;
    localparam logic [1:0] CLS_ZERO = 2'd3;

    // Classify the operands before the multiply.
    always_comb
    begin
        ua      = fisr_pkg::unpack(a);
        ub      = fisr_pkg::unpack(b);
        sp_nan  = ua.is_nan || ub.is_nan || (ua.is_inf && ub.is_zero)
                  || (ub.is_inf && ua.is_zero);
        sp_inf  = ua.is_inf || ub.is_inf;
        sp_zero = ua.is_zero || ub.is_zero;
    end

    // First stage: significand product and exponent sum.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            out_valid <= 1'b0;
        end
        else if (en)
        begin
            v1_reg    <= in_valid;
            out_valid <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg     <= ua.sig * ub.sig;
            e_reg     <= $signed({3'd0, ua.expo}) + $signed({3'd0, ub.expo}) - 11'sd127;
            s_reg     <= ua.sign ^ ub.sign;
            side1_reg <= side_in;
            if (sp_nan)
            begin
                cls_reg <= CLS_NAN;
            end
            else if (sp_inf)
            begin
                cls_reg <= CLS_INF;
            end
            else if (sp_zero)
            begin
                cls_reg <= CLS_ZERO;
            end
            else
            begin
                cls_reg <= CLS_NUM;
            end
        end
    end

    // Second stage: normalise, round and pack.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_out <= side1_reg;
            unique case (cls_reg)
                CLS_NAN:  prod <= fisr_pkg::CANON_NAN;
                CLS_INF:  prod <= {s_reg, 8'hFF, 23'd0};
                CLS_ZERO: prod <= {s_reg, 31'd0};
                default:  prod <= fisr_pkg::mul_round(s_reg, p_reg, e_reg);
            endcase
        end
    end

endmodule
`default_nettype wire

// File: rtl/fisr_fsub.sv
`default_nettype none
// Two-stage 1.5 - t, round to nearest even, flush to zero.
module fisr_fsub (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        en,
    input  wire logic        in_valid,
    input  wire logic [31:0] t,
    input  wire logic [31:0] side_in,
    output logic             out_valid,
    output logic [31:0]      diff,
    output logic [31:0]      side_out
);

    // Operands as a = 1.5 and b = -t, added with sticky alignment.
    fisr_pkg::fp_unp_t ua;
    fisr_pkg::fp_unp_t ub;
    fisr_pkg::fp_unp_t big;
    fisr_pkg::fp_unp_t lit;
    logic [7:0]        dexp;
    logic [26:0]       sl;
    logic [26:0]       bl;
    logic              stk;
    logic              swap;

    logic         v1_reg;
    logic         sub_reg;
    logic         sgn_reg;
    logic [7:0]   ex_reg;
    logic [26:0]  bm_reg;
    logic [26:0]  lm_reg;
    logic         spec_reg;
    logic [31:0]  spec_val_reg;
    logic [31:0]  side1_reg;

    logic [27:0]  sum;
    logic [4:0]   lz;
    logic [27:0]  nm;
    logic signed [9:0] e2;
    logic [24:0]  mr;
    logic [31:0]  res;

    always_comb
    begin
        ua = fisr_pkg::unpack(fisr_pkg::THREE_HALF);
        ub = fisr_pkg::unpack({~t[31], t[30:0]});
        swap = (ub.expo > ua.expo) || ((ub.expo == ua.expo) && (ub.sig > ua.sig));
        big = swap ? ub : ua;
        lit = swap ? ua : ub;
        if (lit.is_zero)
        begin
            lit.sig = 24'd0;
        end
        dexp = big.expo - lit.expo;
        bl   = {big.sig, 3'd0};
        sl   = {lit.sig, 3'd0};
        stk  = 1'b0;
        if (dexp >= 8'd27)
        begin
            stk = |sl;
            sl  = 27'd0;
        end
        else
        begin
            stk = |(sl & ((27'd1 << dexp) - 27'd1));
            sl  = sl >> dexp;
        end
        sl[0] = sl[0] | stk;
    end

    // First stage: align the smaller operand; handle NaN and infinity.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            out_valid <= 1'b0;
        end
        else if (en)
        begin
            v1_reg    <= in_valid;
            out_valid <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sub_reg      <= big.sign ^ lit.sign;
            sgn_reg      <= big.sign;
            ex_reg       <= big.expo;
            bm_reg       <= bl;
            lm_reg       <= sl;
            spec_reg     <= ub.is_nan || ub.is_inf;
            spec_val_reg <= ub.is_nan ? fisr_pkg::CANON_NAN : {ub.sign, 8'hFF, 23'd0};
            side1_reg    <= side_in;
        end
    end

    // Second stage: add, normalise, round and pack.
    always_comb
    begin
        sum = sub_reg ? ({1'b0, bm_reg} - {1'b0, lm_reg}) : ({1'b0, bm_reg} + {1'b0, lm_reg});
        // The highest set bit below the carry position sets the left shift.
        lz  = 5'd0;
        for (int i = 0; i <= 26; i++)
        begin
            if (sum[i])
            begin
                lz = 5'(26 - i);
            end
        end
        if (sum[27])
        begin
            nm = {1'b0, sum[27:2], sum[1] | sum[0]};
            e2 = $signed({2'd0, ex_reg}) + 10'sd1;
        end
        else
        begin
            nm = sum << lz;
            e2 = $signed({2'd0, ex_reg}) - $signed({5'd0, lz});
        end
        mr = {1'b0, nm[26:3]} + {24'd0, nm[2] & (nm[1] | nm[0] | nm[3])};
        if (mr[24])
        begin
            mr = {1'b0, mr[24:1]};
            e2 = e2 + 10'sd1;
        end
        if (sum == 28'd0)
        begin
            res = 32'd0;
        end
        else if (e2 >= 10'sd255)
        begin
            res = {sgn_reg, 8'hFF, 23'd0};
        end
        else if (e2 <= 10'sd0)
        begin
            res = {sgn_reg, 31'd0};
        end
        else
        begin
            res = {sgn_reg, e2[7:0], mr[22:0]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_out <= side1_reg;
            diff     <= spec_reg ? spec_val_reg : res;
        end
    end

endmodule
`default_nettype wire

// File: rtl/fast_inverse_square_root_core.sv
`default_nettype none
// Reciprocal square root estimate with one Newton step, IEEE single precision.
// Input channel: operand_bits with in_valid / in_stall; output channel:
// result_bits with out_valid / out_stall. Each item is one 32-bit pattern.
// The bit-trick estimate is formed on entry, then five two-stage floating
// units run in a chain (x*0.5, half*y0, p*y0, 1.5-t, y0*d), ten register
// stages in all. One item is accepted every cycle while in_stall is low;
// the whole chain advances together.
// When the receiver stalls, the whole pipeline holds and in_stall is raised
// only while a valid result waits at the output, so nothing is lost.
// Subnormals are flushed to zero and every NaN result reads 0x7FC00000.
// Reset clears all valid bits; payload registers are not reset.
module fast_inverse_square_root_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [31:0] operand_bits,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      result_bits
);

    logic        en;
    logic [31:0] xb;
    logic [31:0] yb;
    logic        v_h;
    logic        v_p;
    logic        v_t;
    logic        v_d;
    logic [31:0] half;
    logic [31:0] p;
    logic [31:0] t;
    logic [31:0] d;
    logic [31:0] y0_h;
    logic [31:0] y0_p;
    logic [31:0] y0_t;
    logic [31:0] y0_d;
    logic [31:0] unused_side;

    // The chain moves whenever the output slot is free or being taken.
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    // Initial estimate from the flushed bits.
    always_comb
    begin
        xb = fisr_pkg::flush_sub(operand_bits);
        yb = fisr_pkg::MAGIC_BITS - {xb[31], xb[31:1]};
        yb = fisr_pkg::flush_sub(yb);
    end

    fisr_fmul u_half (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_valid),
        .a(xb), .b(fisr_pkg::ONE_HALF), .side_in(yb),
        .out_valid(v_h), .prod(half), .side_out(y0_h)
    );

    fisr_fmul u_p (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v_h),
        .a(half), .b(y0_h), .side_in(y0_h),
        .out_valid(v_p), .prod(p), .side_out(y0_p)
    );

    fisr_fmul u_t (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v_p),
        .a(p), .b(y0_p), .side_in(y0_p),
        .out_valid(v_t), .prod(t), .side_out(y0_t)
    );

    fisr_fsub u_d (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v_t),
        .t(t), .side_in(y0_t),
        .out_valid(v_d), .diff(d), .side_out(y0_d)
    );

    fisr_fmul u_y (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v_d),
        .a(y0_d), .b(d), .side_in(y0_d),
        .out_valid(out_valid), .prod(result_bits), .side_out(unused_side)
    );

endmodule
`default_nettype wire

// File: verif/fast_inverse_square_root_core_test.sv
`timescale 1ns / 1ps

module fast_inverse_square_root_core_test;

    // Class of an unpacked single-precision value.
    typedef enum logic [1:0] {K_ZERO, K_NORM, K_INF, K_NAN} fp_kind_t;

    typedef struct {
        fp_kind_t    kind;
        logic        sgn;
        logic [23:0] mant;
        int          ex;
    } fp_val_t;

    // One row of the directed stimulus.
    typedef struct {
        logic [31:0] operand;
        logic        known;
        logic [31:0] result;
    } vector_row_t;

    localparam int  RANDOM_ITEMS = 1430;
    localparam int  CYCLE_LIMIT  = 400000;
    localparam int  DRAIN_CYCLES = 30;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] operand_bits;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] result_bits;

    logic [31:0] pending_results[$];
    int          fail_count;
    int          cycle_count;
    bit          quiet_phase;
    int          stall_left;

    fast_inverse_square_root_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operand_bits (operand_bits),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_bits  (result_bits)
    );

    // Free-running clock.
    always #2 clk = ~clk;

    // Decode a pattern, flushing subnormals to a signed zero.
    function automatic fp_val_t decode_fp(input logic [31:0] b);
        fp_val_t v;
        v.sgn  = b[31];
        v.mant = {1'b1, b[22:0]};
        v.ex   = int'(b[30:23]) - 150;
        if (b[30:23] == 8'hFF)
        begin
            v.kind = (b[22:0] != 23'd0) ? K_NAN : K_INF;
        end
        else if (b[30:23] == 8'd0)
        begin
            v.kind = K_ZERO;
        end
        else
        begin
            v.kind = K_NORM;
        end
        return v;
    endfunction

    // Shift right with round to nearest even.
    function automatic logic [63:0] shift_round(input logic [63:0] v, input int sh);
        logic [127:0] wide;
        logic [127:0] q;
        logic [127:0] rem;
        logic [127:0] half;
        if (sh <= 0)
        begin
            return v << (-sh);
        end
        if (sh >= 100)
        begin
            return 64'd0;
        end
        wide = {64'd0, v};
        q    = wide >> sh;
        rem  = wide - (q << sh);
        half = 128'd1 << (sh - 1);
        if (rem > half || (rem == half && q[0]))
        begin
            q = q + 128'd1;
        end
        return q[63:0];
    endfunction

    // Round the exact value mag * 2^ex to single, then flush a subnormal result.
    function automatic logic [31:0] round_pack(input logic s, input logic [63:0] mag,
                                               input int ex);
        int          msb;
        int          biased;
        int          sh;
        logic [63:0] q;
        logic [31:0] r;
        if (mag == 64'd0)
        begin
            return {s, 31'd0};
        end
        msb = 63;
        while (!mag[msb])
        begin
            msb--;
        end
        biased = msb + ex + 127;
        sh     = msb - 23;
        if (biased < 1)
        begin
            sh = sh + (1 - biased);
        end
        q = shift_round(mag, sh);
        if (biased < 1)
        begin
            // Subnormal range: the encoding is the rounded value itself.
            r = {s, q[30:0]};
        end
        else
        begin
            if (q[24])
            begin
                q      = q >> 1;
                biased = biased + 1;
            end
            if (biased >= 255)
            begin
                r = {s, 8'hFF, 23'd0};
            end
            else
            begin
                r = {s, biased[7:0], q[22:0]};
            end
        end
        if (r[30:23] == 8'd0)
        begin
            r = {s, 31'd0};
        end
        return r;
    endfunction

    function automatic logic [31:0] fp_multiply(input logic [31:0] a, input logic [31:0] b);
        fp_val_t va;
        fp_val_t vb;
        logic    s;
        va = decode_fp(a);
        vb = decode_fp(b);
        s  = va.sgn ^ vb.sgn;
        if (va.kind == K_NAN || vb.kind == K_NAN)
        begin
            return fisr_pkg::CANON_NAN;
        end
        if (va.kind == K_INF || vb.kind == K_INF)
        begin
            // Infinity times zero has no value.
            if (va.kind == K_ZERO || vb.kind == K_ZERO)
            begin
                return fisr_pkg::CANON_NAN;
            end
            return {s, 8'hFF, 23'd0};
        end
        if (va.kind == K_ZERO || vb.kind == K_ZERO)
        begin
            return {s, 31'd0};
        end
        return round_pack(s, 64'(va.mant) * 64'(vb.mant), va.ex + vb.ex);
    endfunction

    function automatic logic [31:0] fp_subtract(input logic [31:0] a, input logic [31:0] b);
        fp_val_t     va;
        fp_val_t     vb;
        fp_val_t     big;
        fp_val_t     lit;
        int          d;
        logic [63:0] big_m;
        logic [63:0] lit_m;
        logic [63:0] shifted;
        logic        lost;
        va     = decode_fp(a);
        vb     = decode_fp(b);
        vb.sgn = ~vb.sgn;
        if (va.kind == K_NAN || vb.kind == K_NAN)
        begin
            return fisr_pkg::CANON_NAN;
        end
        if (va.kind == K_INF && vb.kind == K_INF)
        begin
            return (va.sgn == vb.sgn) ? {va.sgn, 8'hFF, 23'd0} : fisr_pkg::CANON_NAN;
        end
        if (va.kind == K_INF)
        begin
            return {va.sgn, 8'hFF, 23'd0};
        end
        if (vb.kind == K_INF)
        begin
            return {vb.sgn, 8'hFF, 23'd0};
        end
        if (va.kind == K_ZERO && vb.kind == K_ZERO)
        begin
            return {va.sgn & vb.sgn, 31'd0};
        end
        if (va.kind == K_ZERO)
        begin
            return {vb.sgn, b[30:0]};
        end
        if (vb.kind == K_ZERO)
        begin
            return a;
        end
        // Align the smaller operand, keeping a sticky bit for what falls off.
        if (va.ex >= vb.ex)
        begin
            big = va;
            lit = vb;
        end
        else
        begin
            big = vb;
            lit = va;
        end
        d     = big.ex - lit.ex;
        big_m = 64'(big.mant) << 39;
        lit_m = 64'(lit.mant) << 39;
        if (d >= 64)
        begin
            shifted = 64'd1;
        end
        else
        begin
            lost    = (lit_m & ((64'd1 << d) - 64'd1)) != 64'd0;
            shifted = (lit_m >> d) | 64'(lost);
        end
        if (big.sgn == lit.sgn)
        begin
            return round_pack(big.sgn, big_m + shifted, big.ex - 39);
        end
        if (big_m == shifted)
        begin
            return 32'd0;
        end
        if (big_m > shifted)
        begin
            return round_pack(big.sgn, big_m - shifted, big.ex - 39);
        end
        return round_pack(lit.sgn, shifted - big_m, big.ex - 39);
    endfunction

    // Bit-trick estimate followed by one Newton step.
    function automatic logic [31:0] rsqrt_newton(input logic [31:0] operand);
        logic [31:0] xb;
        logic [31:0] y0;
        logic [31:0] half_x;
        logic [31:0] prod;
        logic [31:0] t;
        logic [31:0] d;
        logic [31:0] y;
        xb = operand;
        if (xb[30:23] == 8'd0)
        begin
            xb = {xb[31], 31'd0};
        end
        y0     = fisr_pkg::MAGIC_BITS - {xb[31], xb[31:1]};
        half_x = fp_multiply(xb, fisr_pkg::ONE_HALF);
        prod   = fp_multiply(half_x, y0);
        t      = fp_multiply(prod, y0);
        d      = fp_subtract(fisr_pkg::THREE_HALF, t);
        y      = fp_multiply(y0, d);
        if (y[30:23] == 8'hFF && y[22:0] != 23'd0)
        begin
            y = fisr_pkg::CANON_NAN;
        end
        return y;
    endfunction

    // Offer one operand and wait until it is taken.
    task automatic send_operand(input logic [31:0] value, input logic known,
                                input logic [31:0] typed);
        int gap;
        gap = quiet_phase ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        operand_bits <= value;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        pending_results.push_back(known ? typed : rsqrt_newton(value));
    endtask

    // Random operand, mostly ordinary positive values, some extreme exponents.
    function automatic logic [31:0] random_operand();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
        begin
            return {1'b0, 8'($urandom_range(100, 160)), 23'($urandom)};
        end
        if (pick < 6)
        begin
            return {1'($urandom), ($urandom_range(0, 1) ? 8'hFF : 8'($urandom_range(0, 3))),
                    23'($urandom)};
        end
        if (pick < 7)
        begin
            return {1'($urandom), 8'($urandom_range(240, 254)), 23'($urandom)};
        end
        return $urandom;
    endfunction

    // Result side: check each item taken and draw its stall.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result_bits: none expected, actual %h", result_bits);
                fail_count++;
            end
            else
            begin
                if (result_bits !== pending_results[0])
                begin
                    $error("result_bits: expected %h, actual %h", pending_results[0],
                           result_bits);
                    fail_count++;
                end
                void'(pending_results.pop_front());
            end
            stall_left = quiet_phase ? 0 : $urandom_range(0, 9);
        end
        out_stall <= (stall_left != 0);
        if (stall_left != 0)
        begin
            stall_left--;
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        vector_row_t vectors[20];
        clk          = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        operand_bits = 32'd0;
        out_stall    = 1'b0;
        fail_count   = 0;
        cycle_count  = 0;
        quiet_phase  = 1'b0;
        stall_left   = 0;

        // Directed rows: NaN inputs are typed in, the rest go through the predictor.
        vectors = '{
            '{32'h0000_0000, 1'b0, 32'd0}, '{32'h8000_0000, 1'b0, 32'd0},
            '{32'h0000_0001, 1'b0, 32'd0}, '{32'h007F_FFFF, 1'b0, 32'd0},
            '{32'h8000_0001, 1'b0, 32'd0}, '{32'h0080_0000, 1'b0, 32'd0},
            '{32'h3F80_0000, 1'b0, 32'd0}, '{32'h4080_0000, 1'b0, 32'd0},
            '{32'h3E80_0000, 1'b0, 32'd0}, '{32'h7F7F_FFFF, 1'b0, 32'd0},
            '{32'h7F80_0000, 1'b0, 32'd0}, '{32'hFF80_0000, 1'b0, 32'd0},
            '{32'h7FC0_0000, 1'b1, fisr_pkg::CANON_NAN},
            '{32'h7F80_0001, 1'b1, fisr_pkg::CANON_NAN},
            '{32'hFFFF_FFFF, 1'b1, fisr_pkg::CANON_NAN},
            '{32'hFFC0_0000, 1'b1, fisr_pkg::CANON_NAN},
            '{32'hBF80_0000, 1'b0, 32'd0}, '{32'h5F37_59DF, 1'b0, 32'd0},
            '{32'hAAAA_AAAA, 1'b0, 32'd0}, '{32'h5555_5555, 1'b0, 32'd0}
        };

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (vectors[i])
        begin
            send_operand(vectors[i].operand, vectors[i].known, vectors[i].result);
        end

        // Random part, in runs with and without idling chosen at random.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 100 == 0)
            begin
                quiet_phase = ($urandom_range(0, 3) == 0);
            end
            if (n == RANDOM_ITEMS / 2)
            begin
                in_valid <= 1'b0;
                while (pending_results.size() != 0)
                begin
                    @(posedge clk);
                end
                @(posedge clk);
            end
            send_operand(random_operand(), 1'b0, 32'd0);
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
